// ===== rtl/core/counting_hash_table_linear_probe_defines.svh =====
// ----------------------------------------------------------------------------
// counting hash table assertion macros
// shared property templates for cht_checker
// ----------------------------------------------------------------------------
`ifndef COUNTING_HASH_TABLE_LINEAR_PROBE_DEFINES_SVH
`define COUNTING_HASH_TABLE_LINEAR_PROBE_DEFINES_SVH

// same-cycle implication, clocked on clk, off while rst is high
`define CHT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off while rst is high
`define CHT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/cht_pkg.sv =====
// ----------------------------------------------------------------------------
// cht_pkg
// types, constants and helpers of the counting hash table
// ----------------------------------------------------------------------------
`default_nettype none

package cht_pkg;

  // table geometry; slot count must be a power of two
  localparam int TABLE_SLOTS  = 256;
  localparam int KEY_WORDS    = 4;
  localparam int PAYLOAD_BITS = 32;
  localparam int COUNT_BITS   = 32;

  localparam int SLOT_BITS  = $clog2(TABLE_SLOTS);
  localparam int OCC_BITS   = SLOT_BITS + 1;
  localparam int KIDX_BITS  = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
  localparam int KADDR_BITS = $clog2(TABLE_SLOTS * KEY_WORDS);
  localparam int ENTRY_BITS = 1 + PAYLOAD_BITS + COUNT_BITS;

  // hash schedule: full groups of three words, then a tail of one to three
  localparam logic [31:0] HASH_SEED = 32'hdeadbeef;
  localparam int HASH_GROUPS = (KEY_WORDS - 1) / 3;
  localparam int HASH_TAIL   = KEY_WORDS - 3 * HASH_GROUPS;
  localparam int HW_DEPTH    = 3 * HASH_GROUPS + 3;
  localparam int GRP_BITS    = 3;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_NEW    = 2'd0,
    ST_MERGED = 2'd1,
    ST_FULL   = 2'd2,
    ST_READ   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OSEL_NEW,
    OSEL_NEWZ,
    OSEL_MERGE,
    OSEL_FULL,
    OSEL_READ
  } out_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HINIT,
    S_HASH,
    S_HOME,
    S_PCHECK,
    S_KWAIT,
    S_KCMP,
    S_KDEC,
    S_WKEY,
    S_WENT,
    S_ZERO,
    S_FULL,
    S_RWAIT,
    S_REMIT
  } state_t;

  typedef struct packed {
    logic     take_word;
    logic     take_read;
    logic     clear;
    logic     hash_load;
    logic     hash_step;
    logic     probe_start;
    logic     probe_next;
    logic     kidx_clr;
    logic     kidx_inc;
    logic     match_upd;
    logic     wr_key;
    logic     wr_entry;
    logic     out_load;
    out_sel_t out_sel;
  } ctl_t;

  typedef struct packed {
    logic last_word;
    logic hash_last;
    logic slot_valid;
    logic kidx_end;
    logic key_match;
    logic probe_last;
    logic cnt_zero;
    logic out_busy;
  } sts_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned k);
    return (x << k) | (x >> (32 - k));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cht_in_if.sv =====
// ----------------------------------------------------------------------------
// cht_in_if
// command channel: key words, reads and clears
// ----------------------------------------------------------------------------
`default_nettype none

interface cht_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] key_word;
  logic [31:0] payload;
  logic [31:0] add_count;
  logic        ok_flag;
  logic [7:0]  slot_index;

  modport source (output valid, cmd, key_word, payload, add_count, ok_flag, slot_index,
                  input ready);
  modport sink   (input valid, cmd, key_word, payload, add_count, ok_flag, slot_index,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cht_out_if.sv =====
// ----------------------------------------------------------------------------
// cht_out_if
// result channel: insert status and slot read data
// ----------------------------------------------------------------------------
`default_nettype none

interface cht_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  slot;
  logic [31:0] entry_count;
  logic        entry_ok;
  logic [31:0] entry_payload;
  logic [31:0] out_key_word;
  logic        last;
  logic [8:0]  occupied;

  modport source (output valid, status, slot, entry_count, entry_ok, entry_payload,
                  out_key_word, last, occupied, input ready);
  modport sink   (input valid, status, slot, entry_count, entry_ok, entry_payload,
                  out_key_word, last, occupied, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cht_ram.sv =====
// ----------------------------------------------------------------------------
// cht_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module cht_ram #(
  parameter int WIDTH     = 32,
  parameter int DEPTH     = 256,
  parameter int ADDR_BITS = $clog2(DEPTH)
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic [ADDR_BITS-1:0] raddr,
  output logic      [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/cht_ctrl.sv =====
// ----------------------------------------------------------------------------
// cht_ctrl
// sequencer for key intake, hashing, probing, inserts and slot reads
// ----------------------------------------------------------------------------
`default_nettype none

module cht_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic [1:0]    in_cmd,
  output logic               in_ready,
  input  wire cht_pkg::sts_t sts,
  output cht_pkg::ctl_t      ctl
);

  cht_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cht_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    ctl         = '0;
    ctl.out_sel = cht_pkg::OSEL_NEW;
    in_ready    = 1'b0;
    unique case (state)
      cht_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_cmd)
            cht_pkg::CMD_ADD: begin
              ctl.take_word = 1'b1;
              if (sts.last_word) state_next = cht_pkg::S_HINIT;
            end
            cht_pkg::CMD_READ: begin
              ctl.take_read = 1'b1;
              ctl.kidx_clr  = 1'b1;
              state_next    = cht_pkg::S_RWAIT;
            end
            cht_pkg::CMD_CLEAR: ctl.clear = 1'b1;
            default: ;
          endcase
        end
      end
      cht_pkg::S_HINIT: begin
        ctl.hash_load = 1'b1;
        state_next    = cht_pkg::S_HASH;
      end
      cht_pkg::S_HASH: begin
        ctl.hash_step = 1'b1;
        if (sts.hash_last) state_next = cht_pkg::S_HOME;
      end
      cht_pkg::S_HOME: begin
        ctl.probe_start = 1'b1;
        state_next      = cht_pkg::S_PCHECK;
      end
      cht_pkg::S_PCHECK: begin
        ctl.kidx_clr = 1'b1;
        if (!sts.slot_valid) begin
          state_next = sts.cnt_zero ? cht_pkg::S_ZERO : cht_pkg::S_WKEY;
        end else begin
          state_next = cht_pkg::S_KWAIT;
        end
      end
      cht_pkg::S_KWAIT: state_next = cht_pkg::S_KCMP;
      cht_pkg::S_KCMP: begin
        ctl.match_upd = 1'b1;
        if (sts.kidx_end) begin
          state_next = cht_pkg::S_KDEC;
        end else begin
          ctl.kidx_inc = 1'b1;
          state_next   = cht_pkg::S_KWAIT;
        end
      end
      cht_pkg::S_KDEC: begin
        priority if (sts.key_match) begin
          if (!sts.out_busy) begin
            ctl.wr_entry = 1'b1;
            ctl.out_load = 1'b1;
            ctl.out_sel  = cht_pkg::OSEL_MERGE;
            state_next   = cht_pkg::S_IDLE;
          end
        end else if (sts.probe_last) begin
          state_next = cht_pkg::S_FULL;
        end else begin
          ctl.probe_next = 1'b1;
          state_next     = cht_pkg::S_PCHECK;
        end
      end
      cht_pkg::S_WKEY: begin
        ctl.wr_key = 1'b1;
        if (sts.kidx_end) begin
          state_next = cht_pkg::S_WENT;
        end else begin
          ctl.kidx_inc = 1'b1;
        end
      end
      cht_pkg::S_WENT: begin
        if (!sts.out_busy) begin
          ctl.wr_entry = 1'b1;
          ctl.out_load = 1'b1;
          ctl.out_sel  = cht_pkg::OSEL_NEW;
          state_next   = cht_pkg::S_IDLE;
        end
      end
      cht_pkg::S_ZERO: begin
        if (!sts.out_busy) begin
          ctl.out_load = 1'b1;
          ctl.out_sel  = cht_pkg::OSEL_NEWZ;
          state_next   = cht_pkg::S_IDLE;
        end
      end
      cht_pkg::S_FULL: begin
        if (!sts.out_busy) begin
          ctl.out_load = 1'b1;
          ctl.out_sel  = cht_pkg::OSEL_FULL;
          state_next   = cht_pkg::S_IDLE;
        end
      end
      cht_pkg::S_RWAIT: state_next = cht_pkg::S_REMIT;
      cht_pkg::S_REMIT: begin
        if (!sts.out_busy) begin
          ctl.out_load = 1'b1;
          ctl.out_sel  = cht_pkg::OSEL_READ;
          if (sts.kidx_end) begin
            state_next = cht_pkg::S_IDLE;
          end else begin
            ctl.kidx_inc = 1'b1;
            state_next   = cht_pkg::S_RWAIT;
          end
        end
      end
      default: state_next = cht_pkg::S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/cht_dp.sv =====
// ----------------------------------------------------------------------------
// cht_dp
// key buffer, hash unit, probe pointer, slot stores and result register
// ----------------------------------------------------------------------------
`default_nettype none

module cht_dp #(
  parameter int TABLE_SLOTS = cht_pkg::TABLE_SLOTS,
  parameter int KEY_WORDS   = cht_pkg::KEY_WORDS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cht_pkg::ctl_t      ctl,
  output cht_pkg::sts_t           sts,
  input  wire logic [31:0]        key_word,
  input  wire logic [31:0]        payload,
  input  wire logic [31:0]        add_count,
  input  wire logic               ok_flag,
  input  wire logic [7:0]         slot_index,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  output cht_pkg::status_t        rsp_status,
  output logic [7:0]              rsp_slot,
  output logic [31:0]             rsp_entry_count,
  output logic                    rsp_entry_ok,
  output logic [31:0]             rsp_entry_payload,
  output logic [31:0]             rsp_out_key_word,
  output logic                    rsp_last,
  output logic [8:0]              rsp_occupied
);

  localparam int SLOT_BITS   = $clog2(TABLE_SLOTS);
  localparam int OCC_BITS    = SLOT_BITS + 1;
  localparam int KIDX_BITS   = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
  localparam int KADDR_BITS  = $clog2(TABLE_SLOTS * KEY_WORDS);
  // hash schedule follows this instance's key length
  localparam int HASH_GROUPS = (KEY_WORDS - 1) / 3;
  localparam int HASH_TAIL   = KEY_WORDS - 3 * HASH_GROUPS;
  localparam int HW_DEPTH    = 3 * HASH_GROUPS + 3;
  localparam int GRP_BITS    = cht_pkg::GRP_BITS;
  localparam int ENTRY_BITS  = cht_pkg::ENTRY_BITS;

  // key intake
  logic [31:0]          key_buf [KEY_WORDS];
  logic [KIDX_BITS-1:0] word_idx;
  logic [31:0]          pay_reg, cnt_reg;
  logic                 ok_reg;

  // hash unit
  logic [31:0]         ha, hb, hc, ha_next, hb_next, hc_next;
  logic [31:0]         hw [HW_DEPTH];
  logic                fin;
  logic [2:0]          op;
  logic [GRP_BITS-1:0] grp;

  // probe
  logic [SLOT_BITS-1:0] slot, home;
  logic [OCC_BITS-1:0]  probe_cnt;
  logic [KIDX_BITS-1:0] kidx;
  logic                 match;
  logic [TABLE_SLOTS-1:0] filled;
  logic [OCC_BITS-1:0]  occ, occ_next;

  // stores
  logic [KADDR_BITS-1:0] kaddr;
  logic [31:0]           key_rdata;
  logic [ENTRY_BITS-1:0] ent_rdata, ent_wdata;
  logic [31:0]           ent_cnt, ent_pay, merged;
  logic                  ent_ok;
  logic [32:0]           sum;

  assign kaddr = KADDR_BITS'(KADDR_BITS'(slot) * KADDR_BITS'(KEY_WORDS)) + KADDR_BITS'(kidx);
  assign {ent_ok, ent_pay, ent_cnt} = ent_rdata;
  assign sum    = {1'b0, ent_cnt} + {1'b0, cnt_reg};
  assign merged = sum[32] ? '1 : sum[31:0];
  assign ent_wdata = (ctl.out_sel == cht_pkg::OSEL_MERGE) ? {ent_ok, ent_pay, merged}
                                                          : {ok_reg, pay_reg, cnt_reg};

  cht_ram #(.WIDTH(32), .DEPTH(TABLE_SLOTS * KEY_WORDS)) u_key_ram (
    .clk   (clk),
    .we    (ctl.wr_key),
    .waddr (kaddr),
    .wdata (key_buf[kidx]),
    .raddr (kaddr),
    .rdata (key_rdata)
  );

  cht_ram #(.WIDTH(ENTRY_BITS), .DEPTH(TABLE_SLOTS)) u_entry_ram (
    .clk   (clk),
    .we    (ctl.wr_entry),
    .waddr (slot),
    .wdata (ent_wdata),
    .raddr (slot),
    .rdata (ent_rdata)
  );

  assign occ_next = (ctl.wr_entry && ctl.out_sel == cht_pkg::OSEL_NEW) ? occ + 1'b1 : occ;

  assign sts.last_word  = (word_idx == KIDX_BITS'(KEY_WORDS - 1));
  assign sts.hash_last  = fin && (op == 3'd7);
  assign sts.slot_valid = filled[slot];
  assign sts.kidx_end   = (kidx == KIDX_BITS'(KEY_WORDS - 1));
  assign sts.key_match  = match;
  assign sts.probe_last = (probe_cnt == OCC_BITS'(TABLE_SLOTS - 1));
  assign sts.cnt_zero   = (cnt_reg == '0);
  assign sts.out_busy   = rsp_valid && !rsp_ready;

  // one hash round per cycle
  always_comb begin
    ha_next = ha;
    hb_next = hb;
    hc_next = hc;
    if (!fin) begin
      unique case (op)
        3'd0: begin
          ha_next = ha + hw[0];
          hb_next = hb + hw[1];
          hc_next = hc + hw[2];
        end
        3'd1: begin ha_next = (ha - hc) ^ cht_pkg::rotl(hc, 4);  hc_next = hc + hb; end
        3'd2: begin hb_next = (hb - ha) ^ cht_pkg::rotl(ha, 6);  ha_next = ha + hc; end
        3'd3: begin hc_next = (hc - hb) ^ cht_pkg::rotl(hb, 8);  hb_next = hb + ha; end
        3'd4: begin ha_next = (ha - hc) ^ cht_pkg::rotl(hc, 16); hc_next = hc + hb; end
        3'd5: begin hb_next = (hb - ha) ^ cht_pkg::rotl(ha, 19); ha_next = ha + hc; end
        3'd6: begin hc_next = (hc - hb) ^ cht_pkg::rotl(hb, 4);  hb_next = hb + ha; end
        default: ;
      endcase
    end else begin
      unique case (op)
        3'd0: begin
          ha_next = ha + hw[0];
          if (HASH_TAIL >= 2) hb_next = hb + hw[1];
          if (HASH_TAIL >= 3) hc_next = hc + hw[2];
        end
        3'd1: hc_next = (hc ^ hb) - cht_pkg::rotl(hb, 14);
        3'd2: ha_next = (ha ^ hc) - cht_pkg::rotl(hc, 11);
        3'd3: hb_next = (hb ^ ha) - cht_pkg::rotl(ha, 25);
        3'd4: hc_next = (hc ^ hb) - cht_pkg::rotl(hb, 16);
        3'd5: ha_next = (ha ^ hc) - cht_pkg::rotl(hc, 4);
        3'd6: hb_next = (hb ^ ha) - cht_pkg::rotl(ha, 14);
        3'd7: hc_next = (hc ^ hb) - cht_pkg::rotl(hb, 24);
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      word_idx  <= '0;
      filled    <= '0;
      occ       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (ctl.clear) begin
        word_idx <= '0;
        filled   <= '0;
        occ      <= '0;
      end else begin
        if (ctl.take_word) begin
          word_idx <= sts.last_word ? '0 : word_idx + 1'b1;
        end
        if (ctl.wr_entry) begin
          filled[slot] <= 1'b1;
        end
        occ <= occ_next;
      end
      if (ctl.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.take_word) begin
      key_buf[word_idx] <= key_word;
      if (sts.last_word) begin
        pay_reg <= payload;
        cnt_reg <= add_count;
        ok_reg  <= ok_flag;
      end
    end

    if (ctl.hash_load) begin
      ha  <= cht_pkg::HASH_SEED;
      hb  <= cht_pkg::HASH_SEED;
      hc  <= cht_pkg::HASH_SEED;
      fin <= (HASH_GROUPS == 0);
      op  <= '0;
      grp <= '0;
      for (int i = 0; i < KEY_WORDS; i++) begin
        hw[i] <= key_buf[i];
      end
      for (int i = KEY_WORDS; i < HW_DEPTH; i++) begin
        hw[i] <= '0;
      end
    end else if (ctl.hash_step) begin
      ha <= ha_next;
      hb <= hb_next;
      hc <= hc_next;
      if (!fin && op == 3'd6) begin
        // group done: drop its three words
        op  <= '0;
        grp <= grp + 1'b1;
        if (grp == GRP_BITS'(HASH_GROUPS - 1)) fin <= 1'b1;
        for (int i = 0; i < HW_DEPTH - 3; i++) begin
          hw[i] <= hw[i + 3];
        end
        for (int i = HW_DEPTH - 3; i < HW_DEPTH; i++) begin
          hw[i] <= '0;
        end
      end else begin
        op <= op + 1'b1;
      end
    end

    if (ctl.probe_start) begin
      slot      <= hc[SLOT_BITS-1:0];
      home      <= hc[SLOT_BITS-1:0];
      probe_cnt <= '0;
    end else if (ctl.probe_next) begin
      slot      <= slot + 1'b1;
      probe_cnt <= probe_cnt + 1'b1;
    end else if (ctl.take_read) begin
      slot <= slot_index[SLOT_BITS-1:0];
    end

    if (ctl.kidx_clr) begin
      kidx <= '0;
    end else if (ctl.kidx_inc) begin
      kidx <= kidx + 1'b1;
    end

    if (ctl.match_upd) begin
      match <= (kidx == '0 || match) && (key_rdata == key_buf[kidx]);
    end

    if (ctl.out_load) begin
      rsp_slot         <= 8'(slot);
      rsp_out_key_word <= '0;
      rsp_last         <= 1'b1;
      rsp_occupied     <= 9'(occ_next);
      rsp_entry_count  <= '0;
      rsp_entry_ok     <= 1'b0;
      rsp_entry_payload <= '0;
      unique case (ctl.out_sel)
        cht_pkg::OSEL_NEW: begin
          rsp_status        <= cht_pkg::ST_NEW;
          rsp_entry_count   <= cnt_reg;
          rsp_entry_ok      <= ok_reg;
          rsp_entry_payload <= pay_reg;
        end
        cht_pkg::OSEL_NEWZ: rsp_status <= cht_pkg::ST_NEW;
        cht_pkg::OSEL_MERGE: begin
          rsp_status        <= cht_pkg::ST_MERGED;
          rsp_entry_count   <= merged;
          rsp_entry_ok      <= ent_ok;
          rsp_entry_payload <= ent_pay;
        end
        cht_pkg::OSEL_FULL: begin
          rsp_status <= cht_pkg::ST_FULL;
          rsp_slot   <= 8'(home);
        end
        cht_pkg::OSEL_READ: begin
          rsp_status <= cht_pkg::ST_READ;
          rsp_last   <= sts.kidx_end;
          if (filled[slot]) begin
            rsp_entry_count   <= ent_cnt;
            rsp_entry_ok      <= ent_ok;
            rsp_entry_payload <= ent_pay;
            rsp_out_key_word  <= key_rdata;
          end
        end
        default: rsp_status <= cht_pkg::ST_NEW;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/counting_hash_table_linear_probe.sv =====
// ----------------------------------------------------------------------------
// counting_hash_table_linear_probe
// counting hash table, open addressing with linear probing
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake      carries
//   -------  ---  -------------  ------------------------------------------
//   req      in   valid / ready  cmd, key_word, payload, add_count, ok_flag,
//                                slot_index
//   rsp      out  valid / ready  status, slot, entry_count, entry_ok,
//                                entry_payload, out_key_word, last, occupied
//
// a key word that is not the last one is only buffered; an add on the last
// word hashes the key (groups of three words, then the tail), probes from
// the home slot, comparing the key of each occupied slot word by word, and
// on a free slot stores a new key unless add_count is zero
// a read returns KEY_WORDS items, each after a registered key ram read
// reset is synchronous; the valid bit per slot clears at once, no sweep
// a clear empties the table through the valid bits
// the result register frees up as soon as rsp takes its item; until then the
// sequencer parks in its emitting state
//
`default_nettype none

module counting_hash_table_linear_probe #(
  parameter int TABLE_SLOTS = cht_pkg::TABLE_SLOTS,
  parameter int KEY_WORDS   = cht_pkg::KEY_WORDS
) (
  input  wire logic  clk,
  input  wire logic  rst,
  cht_in_if.sink     req,
  cht_out_if.source  rsp
);

  cht_pkg::ctl_t    ctl;
  cht_pkg::sts_t    sts;
  cht_pkg::status_t status;

  // sequencer: takes req items only while idle
  cht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_cmd   (req.cmd),
    .in_ready (req.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // key buffer, hash unit, stores and the result register
  cht_dp #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .KEY_WORDS   (KEY_WORDS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .ctl               (ctl),
    .sts               (sts),
    .key_word          (req.key_word),
    .payload           (req.payload),
    .add_count         (req.add_count),
    .ok_flag           (req.ok_flag),
    .slot_index        (req.slot_index),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_status        (status),
    .rsp_slot          (rsp.slot),
    .rsp_entry_count   (rsp.entry_count),
    .rsp_entry_ok      (rsp.entry_ok),
    .rsp_entry_payload (rsp.entry_payload),
    .rsp_out_key_word  (rsp.out_key_word),
    .rsp_last          (rsp.last),
    .rsp_occupied      (rsp.occupied)
  );

  assign rsp.status = status;

endmodule

`default_nettype wire

// ===== rtl/core/cht_checker.sv =====
// ----------------------------------------------------------------------------
// cht_checker
// port-level checks on the result channel, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "counting_hash_table_linear_probe_defines.svh"

module cht_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [1:0]  rsp_status,
  input wire logic [7:0]  rsp_slot,
  input wire logic [31:0] rsp_entry_count,
  input wire logic        rsp_entry_ok,
  input wire logic [31:0] rsp_entry_payload,
  input wire logic [31:0] rsp_out_key_word,
  input wire logic        rsp_last,
  input wire logic [8:0]  rsp_occupied
);

  localparam logic [8:0] SLOTS = 9'(cht_pkg::TABLE_SLOTS);

  `CHT_ASSERT_NOW(a_occ_range, rsp_valid, rsp_occupied <= SLOTS, "occupied above table size")

  `CHT_ASSERT_NOW(a_add_single, rsp_valid && rsp_status != cht_pkg::ST_READ,
                  rsp_last && rsp_out_key_word == '0, "insert result not single or has key")

  `CHT_ASSERT_NOW(a_full_table, rsp_valid && rsp_status == cht_pkg::ST_FULL,
                  rsp_entry_count == '0 && rsp_occupied == SLOTS, "full status with free slots")

  `CHT_ASSERT_NOW(a_empty_read, rsp_valid && rsp_status == cht_pkg::ST_READ && rsp_entry_count == '0,
                  !rsp_entry_ok && rsp_entry_payload == '0 && rsp_out_key_word == '0,
                  "empty slot read shows data")

  `CHT_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready,
                  rsp_valid && $stable(rsp_status) && $stable(rsp_slot), "stalled result changed")

endmodule

bind counting_hash_table_linear_probe cht_checker u_cht_checker (
  .clk               (clk),
  .rst               (rst),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_status        (rsp.status),
  .rsp_slot          (rsp.slot),
  .rsp_entry_count   (rsp.entry_count),
  .rsp_entry_ok      (rsp.entry_ok),
  .rsp_entry_payload (rsp.entry_payload),
  .rsp_out_key_word  (rsp.out_key_word),
  .rsp_last          (rsp.last),
  .rsp_occupied      (rsp.occupied)
);

`default_nettype wire
